/* rtl/voxel_grid_ray_traversal_core_assert.svh */
// Assertion macros used by the core RTL file.
`ifndef VOXEL_GRID_RAY_TRAVERSAL_CORE_ASSERT_SVH
`define VOXEL_GRID_RAY_TRAVERSAL_CORE_ASSERT_SVH
`ifndef ASSERT_OFF
`define VGRT_ASSERT_IMP(lbl, a, b) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("assertion failed");
`define VGRT_ASSERT_NXT(lbl, a, b) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("assertion failed");
`else
`define VGRT_ASSERT_IMP(lbl, a, b)
`define VGRT_ASSERT_NXT(lbl, a, b)
`endif
`endif

/* rtl/vgrt_pkg.sv */
package vgrt_pkg;

    localparam int GRID_MAX_W_DEF = 64;
    localparam int GRID_MAX_H_DEF = 64;
    localparam int GRID_MAX_D_DEF = 64;

    localparam logic [6:0] GRID_W_RST     = 7'd64;
    localparam logic [6:0] GRID_H_RST     = 7'd64;
    localparam logic [6:0] GRID_D_RST     = 7'd64;
    localparam logic [7:0] STEP_LIMIT_RST = 8'd200;

    localparam logic [1:0] REG_GRID_WIDTH  = 2'd0;
    localparam logic [1:0] REG_GRID_HEIGHT = 2'd1;
    localparam logic [1:0] REG_GRID_DEPTH  = 2'd2;
    localparam logic [1:0] REG_STEP_LIMIT  = 2'd3;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_RAY   = 1'b1;

    typedef logic [5:0]         coord_t;
    typedef logic signed [17:0] origin_t;
    typedef logic signed [15:0] dir_t;
    typedef logic signed [1:0]  normal_t;

endpackage

/* rtl/vgrt_req_if.sv */
interface vgrt_req_if;
    import vgrt_pkg::*;

    logic    valid;
    logic    ready;
    logic    op;
    coord_t  cell_wx;
    coord_t  cell_wy;
    coord_t  cell_wz;
    logic [7:0] cell_value;
    origin_t origin_x;
    origin_t origin_y;
    origin_t origin_z;
    dir_t    dir_x;
    dir_t    dir_y;
    dir_t    dir_z;
    logic [15:0] max_dist;

    modport source (output valid, op, cell_wx, cell_wy, cell_wz, cell_value,
                    origin_x, origin_y, origin_z, dir_x, dir_y, dir_z, max_dist,
                    input ready);
    modport sink (input valid, op, cell_wx, cell_wy, cell_wz, cell_value,
                  origin_x, origin_y, origin_z, dir_x, dir_y, dir_z, max_dist,
                  output ready);
endinterface

/* rtl/vgrt_rsp_if.sv */
interface vgrt_rsp_if;
    import vgrt_pkg::*;

    logic    valid;
    logic    ready;
    logic    hit;
    coord_t  hit_x;
    coord_t  hit_y;
    coord_t  hit_z;
    normal_t normal_x;
    normal_t normal_y;
    normal_t normal_z;

    modport source (output valid, hit, hit_x, hit_y, hit_z, normal_x, normal_y, normal_z,
                    input ready);
    modport sink (input valid, hit, hit_x, hit_y, hit_z, normal_x, normal_y, normal_z,
                  output ready);
endinterface

/* rtl/voxel_grid_ray_traversal_core.sv */
// Channel   Role    Word
// req       sink    one voxel write or one ray cast
// rsp       source  one ray result (hit, cell, face normal)
// apb       slave   grid_width, grid_height, grid_depth, step_limit
//
// After reset a clearing pass writes every occupancy cell, one a cycle; no
// word is taken meanwhile. A ray first runs a setup with the bit-serial
// reciprocal divider, then steps cell by cell; for each visited cell the
// shared multiplier squares the three offsets.
// A finished result waits in the output register; writes are taken meanwhile.
`include "voxel_grid_ray_traversal_core_assert.svh"

module voxel_grid_ray_traversal_core #(
    parameter int GRID_MAX_W = vgrt_pkg::GRID_MAX_W_DEF,
    parameter int GRID_MAX_H = vgrt_pkg::GRID_MAX_H_DEF,
    parameter int GRID_MAX_D = vgrt_pkg::GRID_MAX_D_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    vgrt_req_if.sink    req,
    vgrt_rsp_if.source  rsp,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import vgrt_pkg::*;

    localparam int XW    = $clog2(GRID_MAX_W);
    localparam int YW    = $clog2(GRID_MAX_H);
    localparam int ZW    = $clog2(GRID_MAX_D);
    localparam int AW    = XW + YW + ZW;
    localparam int DEPTH = 1 << AW;
    localparam int CW    = 12;
    localparam logic [49:0] SAT_DIST = 50'd1 << 48;

    typedef enum logic [3:0] {
        S_CLR, S_IDLE, S_SETUP, S_DIV, S_MUL, S_SIDE, S_LIM, S_LIMW,
        S_CELL, S_SQ0, S_SQ1, S_SQ2, S_SQ3, S_TEST, S_RD, S_DONE
    } state_t;

    state_t state_reg, state_next;

    logic [6:0] grid_w_reg, grid_h_reg, grid_d_reg;
    logic [7:0] step_limit_reg;

    logic [AW:0]              clr_cnt_reg;
    logic signed [24:0]       pos_reg [3];
    logic signed [CW-1:0]     cell_reg [3];
    dir_t                     dir_reg [3];
    logic [49:0]              side_reg [3];
    logic [31:0]              delta_reg [3];
    normal_t                  norm_reg [3];
    logic [1:0]               axis_reg;
    logic [22:0]              md_reg;
    logic [16:0]              rem_reg;
    logic [31:0]              quo_reg;
    logic [4:0]               div_cnt_reg;
    logic [63:0]              prod_reg;
    logic [61:0]              limsq_reg;
    logic [56:0]              dsq_reg;
    logic [7:0]               cnt_reg;
    logic                     hit_reg;
    logic                     rsp_valid_reg;
    logic                     rsp_hit_reg;
    coord_t                   rsp_x_reg, rsp_y_reg, rsp_z_reg;
    normal_t                  rsp_nx_reg, rsp_ny_reg, rsp_nz_reg;

    logic                     mem [DEPTH];
    logic                     rd_data_reg;
    logic                     mem_we;
    logic [AW-1:0]            mem_waddr;
    logic                     mem_wdata;
    logic [AW-1:0]            mem_raddr;

    logic                     req_acc;
    logic                     wr_ok;
    logic [31:0]              mul_a, mul_b;
    logic [16:0]              ad;
    logic [16:0]              div_shift;
    logic                     div_ge;
    logic [16:0]              t_val;
    logic signed [28:0]       df [3];
    logic [27:0]              adf [3];
    logic                     in_bounds;
    logic [1:0]               ax;
    logic                     rsp_free;

    assign pready = 1'b1;

    always_comb
    begin
        case (paddr[3:2])
            REG_GRID_WIDTH:  prdata = {25'd0, grid_w_reg};
            REG_GRID_HEIGHT: prdata = {25'd0, grid_h_reg};
            REG_GRID_DEPTH:  prdata = {25'd0, grid_d_reg};
            REG_STEP_LIMIT:  prdata = {24'd0, step_limit_reg};
            default:         prdata = 32'd0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_w_reg     <= GRID_W_RST;
            grid_h_reg     <= GRID_H_RST;
            grid_d_reg     <= GRID_D_RST;
            step_limit_reg <= STEP_LIMIT_RST;
        end
        else if (psel && penable && pwrite)
        begin
            case (paddr[3:2])
                REG_GRID_WIDTH:  grid_w_reg     <= pwdata[6:0];
                REG_GRID_HEIGHT: grid_h_reg     <= pwdata[6:0];
                REG_GRID_DEPTH:  grid_d_reg     <= pwdata[6:0];
                REG_STEP_LIMIT:  step_limit_reg <= pwdata[7:0];
                default:         ;
            endcase
        end
    end

    assign req.ready = (state_reg == S_IDLE);
    assign req_acc   = req.valid && req.ready;
    assign wr_ok     = (int'(req.cell_wx) < GRID_MAX_W) && (int'(req.cell_wy) < GRID_MAX_H) &&
                       (int'(req.cell_wz) < GRID_MAX_D);

    assign mem_we    = (state_reg == S_CLR) || (req_acc && req.op == OP_WRITE && wr_ok);
    assign mem_waddr = (state_reg == S_CLR) ? clr_cnt_reg[AW-1:0] :
                       {ZW'(req.cell_wz), YW'(req.cell_wy), XW'(req.cell_wx)};
    assign mem_wdata = (state_reg != S_CLR) && (req.cell_value != 8'd0);
    assign mem_raddr = {ZW'(cell_reg[2]), YW'(cell_reg[1]), XW'(cell_reg[0])};

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        rd_data_reg <= mem[mem_raddr];
    end

    always_comb
    begin
        ad = dir_reg[axis_reg][15] ? -{dir_reg[axis_reg][15], dir_reg[axis_reg]} :
                                     {1'b0, dir_reg[axis_reg]};
        div_shift = {rem_reg[15:0], (div_cnt_reg == 5'd31)};
        div_ge    = div_shift >= ad;
        t_val     = dir_reg[axis_reg][15] ? {1'b0, pos_reg[axis_reg][15:0]} :
                                            (17'h10000 - {1'b0, pos_reg[axis_reg][15:0]});
        for (int a = 0; a < 3; a++)
        begin
            df[a]  = {cell_reg[a][CW-1], cell_reg[a], 16'd0} - 29'(pos_reg[a]);
            adf[a] = df[a][28] ? 28'(-df[a]) : df[a][27:0];
        end
        in_bounds = 1'b1;
        if (cell_reg[0] < 0 || int'(cell_reg[0]) >= int'(grid_w_reg) ||
            int'(cell_reg[0]) >= GRID_MAX_W)
        begin
            in_bounds = 1'b0;
        end
        if (cell_reg[1] < 0 || int'(cell_reg[1]) >= int'(grid_h_reg) ||
            int'(cell_reg[1]) >= GRID_MAX_H)
        begin
            in_bounds = 1'b0;
        end
        if (cell_reg[2] < 0 || int'(cell_reg[2]) >= int'(grid_d_reg) ||
            int'(cell_reg[2]) >= GRID_MAX_D)
        begin
            in_bounds = 1'b0;
        end
        if (side_reg[0] < side_reg[1])
        begin
            ax = (side_reg[0] < side_reg[2]) ? 2'd0 : 2'd2;
        end
        else
        begin
            ax = (side_reg[1] < side_reg[2]) ? 2'd1 : 2'd2;
        end
        case (state_reg)
            S_MUL:
            begin
                mul_a = {15'd0, t_val};
                mul_b = quo_reg;
            end
            S_LIM:
            begin
                mul_a = {9'd0, md_reg};
                mul_b = {9'd0, md_reg};
            end
            S_SQ0:
            begin
                mul_a = {4'd0, adf[0]};
                mul_b = {4'd0, adf[0]};
            end
            S_SQ1:
            begin
                mul_a = {4'd0, adf[1]};
                mul_b = {4'd0, adf[1]};
            end
            S_SQ2:
            begin
                mul_a = {4'd0, adf[2]};
                mul_b = {4'd0, adf[2]};
            end
            default:
            begin
                mul_a = 32'd0;
                mul_b = 32'd0;
            end
        endcase
    end

    assign rsp_free = !rsp_valid_reg || rsp.ready;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_CLR:   if (clr_cnt_reg == (AW+1)'(DEPTH - 1)) state_next = S_IDLE;
            S_IDLE:  if (req_acc && req.op == OP_RAY) state_next = S_SETUP;
            S_SETUP:
            begin
                if (dir_reg[axis_reg] != 16'sd0) state_next = S_DIV;
                else if (axis_reg == 2'd2) state_next = S_LIM;
            end
            S_DIV:   if (div_cnt_reg == 5'd0) state_next = S_MUL;
            S_MUL:   state_next = S_SIDE;
            S_SIDE:  state_next = (axis_reg == 2'd2) ? S_LIM : S_SETUP;
            S_LIM:   state_next = S_LIMW;
            S_LIMW:  state_next = S_CELL;
            S_CELL:  state_next = (cnt_reg >= step_limit_reg) ? S_DONE : S_SQ0;
            S_SQ0:   state_next = S_SQ1;
            S_SQ1:   state_next = S_SQ2;
            S_SQ2:   state_next = S_SQ3;
            S_SQ3:   state_next = S_TEST;
            S_TEST:
                state_next = (!in_bounds || {5'd0, dsq_reg} > limsq_reg) ? S_DONE : S_RD;
            S_RD:    state_next = rd_data_reg ? S_DONE : S_CELL;
            S_DONE:  if (rsp_free) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLR;
            clr_cnt_reg   <= '0;
            rsp_valid_reg <= 1'b0;
            axis_reg      <= 2'd0;
            div_cnt_reg   <= 5'd0;
            cnt_reg       <= 8'd0;
            hit_reg       <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            prod_reg  <= mul_a * mul_b;
            if (rsp_valid_reg && rsp.ready && state_reg != S_DONE)
            begin
                rsp_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_CLR: clr_cnt_reg <= clr_cnt_reg + 1'b1;
                S_IDLE:
                begin
                    if (req_acc && req.op == OP_RAY)
                    begin
                        pos_reg[0] <= 25'(req.origin_x * $signed({1'b0, grid_w_reg}));
                        pos_reg[1] <= 25'(req.origin_y * $signed({1'b0, grid_w_reg}));
                        pos_reg[2] <= 25'(req.origin_z * $signed({1'b0, grid_w_reg}));
                        dir_reg[0] <= req.dir_x;
                        dir_reg[1] <= req.dir_y;
                        dir_reg[2] <= req.dir_z;
                        md_reg     <= 23'(req.max_dist * grid_w_reg);
                        axis_reg   <= 2'd0;
                        hit_reg    <= 1'b0;
                        for (int a = 0; a < 3; a++)
                        begin
                            norm_reg[a] <= 2'sd0;
                        end
                    end
                end
                S_SETUP:
                begin
                    cell_reg[axis_reg] <= CW'(pos_reg[axis_reg] >>> 16);
                    if (dir_reg[axis_reg] == 16'sd0)
                    begin
                        side_reg[axis_reg]  <= SAT_DIST;
                        delta_reg[axis_reg] <= 32'd0;
                        axis_reg            <= axis_reg + 2'd1;
                    end
                    else
                    begin
                        rem_reg     <= 17'd0;
                        quo_reg     <= 32'd0;
                        div_cnt_reg <= 5'd31;
                    end
                end
                S_DIV:
                begin
                    rem_reg     <= div_ge ? (div_shift - ad) : div_shift;
                    quo_reg     <= {quo_reg[30:0], div_ge};
                    div_cnt_reg <= div_cnt_reg - 5'd1;
                end
                S_SIDE:
                begin
                    side_reg[axis_reg]  <= {16'd0, prod_reg[49:16]};
                    delta_reg[axis_reg] <= quo_reg;
                    axis_reg            <= axis_reg + 2'd1;
                end
                S_LIMW:
                begin
                    limsq_reg <= {prod_reg[45:0], 16'd0};
                    cnt_reg   <= 8'd0;
                end
                S_SQ1: dsq_reg <= prod_reg[56:0];
                S_SQ2: dsq_reg <= dsq_reg + prod_reg[56:0];
                S_SQ3: dsq_reg <= dsq_reg + prod_reg[56:0];
                S_RD:
                begin
                    if (rd_data_reg)
                    begin
                        hit_reg <= 1'b1;
                    end
                    else
                    begin
                        cnt_reg <= cnt_reg + 8'd1;
                        for (int a = 0; a < 3; a++)
                        begin
                            if (2'(a) == ax && dir_reg[ax] != 16'sd0)
                            begin
                                norm_reg[a] <= dir_reg[ax][15] ? 2'sd1 : -2'sd1;
                            end
                            else
                            begin
                                norm_reg[a] <= 2'sd0;
                            end
                        end
                        if (dir_reg[ax] != 16'sd0)
                        begin
                            side_reg[ax] <= side_reg[ax] + {18'd0, delta_reg[ax]};
                            if (dir_reg[ax][15])
                            begin
                                cell_reg[ax] <= cell_reg[ax] - CW'(1);
                            end
                            else
                            begin
                                cell_reg[ax] <= cell_reg[ax] + CW'(1);
                            end
                        end
                    end
                end
                S_DONE:
                begin
                    if (rsp_free)
                    begin
                        rsp_valid_reg <= 1'b1;
                        rsp_hit_reg   <= hit_reg;
                        rsp_x_reg     <= hit_reg ? 6'(cell_reg[0]) : 6'd0;
                        rsp_y_reg     <= hit_reg ? 6'(cell_reg[1]) : 6'd0;
                        rsp_z_reg     <= hit_reg ? 6'(cell_reg[2]) : 6'd0;
                        rsp_nx_reg    <= hit_reg ? norm_reg[0] : 2'sd0;
                        rsp_ny_reg    <= hit_reg ? norm_reg[1] : 2'sd0;
                        rsp_nz_reg    <= hit_reg ? norm_reg[2] : 2'sd0;
                    end
                end
                default: ;
            endcase
        end
    end

    assign rsp.valid    = rsp_valid_reg;
    assign rsp.hit      = rsp_hit_reg;
    assign rsp.hit_x    = rsp_x_reg;
    assign rsp.hit_y    = rsp_y_reg;
    assign rsp.hit_z    = rsp_z_reg;
    assign rsp.normal_x = rsp_nx_reg;
    assign rsp.normal_y = rsp_ny_reg;
    assign rsp.normal_z = rsp_nz_reg;

    `VGRT_ASSERT_IMP(a_clr_blocks, state_reg == S_CLR, !req.ready)
    `VGRT_ASSERT_IMP(a_cnt_in_limit, state_reg == S_TEST, cnt_reg < step_limit_reg)
    `VGRT_ASSERT_IMP(a_one_normal, rsp.valid, $countones({rsp.normal_x != 2'sd0, rsp.normal_y != 2'sd0, rsp.normal_z != 2'sd0}) <= 1)
    `VGRT_ASSERT_IMP(a_miss_zero, rsp.valid && !rsp.hit, rsp.hit_x == 6'd0 && rsp.hit_y == 6'd0 && rsp.hit_z == 6'd0)
    `VGRT_ASSERT_NXT(a_done_loads, state_reg == S_DONE && rsp_free, rsp.valid && state_reg == S_IDLE)

endmodule
